// ===== rtl/sss_pkg.sv =====
// sss_pkg: codes, widths and controller/datapath structs of the sparse set slot table
// no dependencies; imported by every other file of the block
package sss_pkg;

  localparam int FUNC_W    = 3;
  localparam int HANDLE_W  = 16;
  localparam int POS_W     = 8;
  localparam int PAYLOAD_W = 64;
  localparam int STATUS_W  = 2;
  localparam int HOUT_W    = 8;
  localparam int IDX_W     = 8;
  localparam int LIVE_W    = 9;

  // free-handle search works on groups of valid bits
  localparam int GRP_W = 16;
  localparam int BIT_W = 4;

  localparam logic [FUNC_W-1:0] FN_GET    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_FULL         = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    RS_ERR  = 3'd0,
    RS_GET  = 3'd1,
    RS_SET  = 3'd2,
    RS_APP  = 3'd3,
    RS_REM  = 3'd4,
    RS_READ = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic             ld_item;
    logic             rd_pos;
    logic             rd_last;
    logic             rd_dpos;
    logic             rd_dat_pos;
    logic             wr_dat_pos;
    logic             append;
    logic             app_srch;
    logic             grp_ld;
    logic             remove;
    logic             out_ld;
    res_sel_t         out_sel;
    st_t              out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              h_oor;
    logic              hit;
    logic              full;
    logic              empty;
    logic              p_oor;
    logic              p_dead;
  } dp_stat_t;

endpackage

// ===== rtl/sss_in_if.sv =====
// sss_in_if: request channel of the sparse set slot table
// depends on sss_pkg for field widths
interface sss_in_if import sss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [HANDLE_W-1:0]  handle;
  logic [POS_W-1:0]     position;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, func, handle, position, payload, input ready);
  modport sink   (input valid, func, handle, position, payload, output ready);
endinterface

// ===== rtl/sss_out_if.sv =====
// sss_out_if: result channel of the sparse set slot table
// depends on sss_pkg for field widths
interface sss_out_if import sss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HOUT_W-1:0]    handle_out;
  logic [IDX_W-1:0]     dense_index;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [LIVE_W-1:0]    live_count;

  modport source (output valid, status, handle_out, dense_index, payload_out, live_count,
                  input ready);
  modport sink   (input valid, status, handle_out, dense_index, payload_out, live_count,
                  output ready);
endinterface

// ===== rtl/sss_datapath.sv =====
// sss_datapath: valid bits, position/owner/data memories, entry count, free search, result word
// depends on sss_pkg; driven by sss_ctrl through dp_cmd_t, reports through dp_stat_t
module sss_datapath import sss_pkg::*; #(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [HANDLE_W-1:0]  in_handle,
  input  logic [POS_W-1:0]     in_position,
  input  logic [PAYLOAD_W-1:0] in_payload,
  output logic [STATUS_W-1:0]  out_status,
  output logic [HOUT_W-1:0]    out_handle,
  output logic [IDX_W-1:0]     out_index,
  output logic [PAYLOAD_W-1:0] out_payload,
  output logic [LIVE_W-1:0]    out_live
);

  localparam int HW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int NG  = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int SW  = GW + BIT_W;
  localparam int PADW = NG * GRP_W;
  localparam logic [31:0] SLOTS_L = 32'(SLOTS);

  // latched item
  logic [FUNC_W-1:0]       func_r;
  logic [HANDLE_W-1:0]     hnd_r;
  logic [POS_W-1:0]        posn_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0]    count_r;

  logic [HW-1:0]           pos_mem [SLOTS];
  logic [HW-1:0]           own_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] dat_mem [SLOTS];
  logic [HW-1:0]           pos_q_r;
  logic [HW-1:0]           own_q_r;
  logic [PAYLOAD_BITS-1:0] dat_q_r;

  logic [HW-1:0] app_h_r;
  logic [HW-1:0] app_pos_r;
  logic [GW-1:0] grp_r;
  logic [GW-1:0] grp_nxt;

  logic [STATUS_W-1:0]  o_status_r;
  logic [HOUT_W-1:0]    o_handle_r;
  logic [IDX_W-1:0]     o_index_r;
  logic [PAYLOAD_W-1:0] o_payload_r;
  logic [LIVE_W-1:0]    o_live_r;

  logic [HW-1:0]   hidx;
  logic [HW-1:0]   pidx;
  logic [HW-1:0]   last;
  logic [HW-1:0]   cnt_idx;
  logic [CW-1:0]   cnt_dec;
  logic [PADW-1:0] vld_pad;
  logic [GRP_W-1:0] grp_word;
  logic [BIT_W-1:0] bit_sel;
  logic [SW-1:0]   srch_full;
  logic [HW-1:0]   srch_h;
  logic [HW-1:0]   app_h;

  assign hidx    = hnd_r[HW-1:0];
  assign pidx    = HW'(posn_r);
  assign cnt_dec = count_r - 1'b1;
  assign last    = cnt_dec[HW-1:0];
  assign cnt_idx = count_r[HW-1:0];

  // slots past the table count as taken
  for (genvar i = 0; i < PADW; i++) begin : g_pad
    if (i < SLOTS) begin : g_real
      assign vld_pad[i] = valid_r[i];
    end else begin : g_fill
      assign vld_pad[i] = 1'b1;
    end
  end

  always_comb begin
    grp_nxt = grp_r;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!(&vld_pad[g*GRP_W +: GRP_W])) grp_nxt = GW'(g);
    end
  end

  assign grp_word = vld_pad[grp_r*GRP_W +: GRP_W];

  always_comb begin
    bit_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!grp_word[b]) bit_sel = BIT_W'(b);
    end
  end

  assign srch_full = {grp_r, bit_sel};
  assign srch_h    = srch_full[HW-1:0];
  assign app_h     = cmd.app_srch ? srch_h : hidx;

  always_comb begin
    stat.func   = func_r;
    stat.h_oor  = {16'd0, hnd_r} >= SLOTS_L;
    stat.hit    = valid_r[hidx];
    stat.full   = count_r == CW'(SLOTS);
    stat.empty  = count_r == '0;
    stat.p_oor  = {24'd0, posn_r} >= SLOTS_L;
    stat.p_dead = {24'd0, posn_r} >= 32'(count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      func_r <= in_func;
      hnd_r  <= in_handle;
      posn_r <= in_position;
      pay_r  <= in_payload[PAYLOAD_BITS-1:0];
    end
    if (cmd.grp_ld) grp_r <= grp_nxt;
    if (cmd.append) begin
      app_h_r   <= app_h;
      app_pos_r <= cnt_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.append) begin
      valid_r[app_h] <= 1'b1;
      count_r        <= count_r + 1'b1;
    end else if (cmd.remove) begin
      valid_r[hidx] <= 1'b0;
      count_r       <= cnt_dec;
    end
  end

  // memory write ports
  logic                    pos_we;
  logic [HW-1:0]           pos_wa;
  logic [HW-1:0]           pos_wd;
  logic                    own_we;
  logic [HW-1:0]           own_wa;
  logic [HW-1:0]           own_wd;
  logic                    dat_we;
  logic [HW-1:0]           dat_wa;
  logic [PAYLOAD_BITS-1:0] dat_wd;
  logic                    own_re;
  logic [HW-1:0]           own_ra;
  logic                    dat_re;
  logic [HW-1:0]           dat_ra;

  always_comb begin
    pos_we = cmd.append | cmd.remove;
    pos_wa = cmd.append ? app_h   : own_q_r;
    pos_wd = cmd.append ? cnt_idx : pos_q_r;
    own_we = cmd.append | cmd.remove;
    own_wa = cmd.append ? cnt_idx : pos_q_r;
    own_wd = cmd.append ? app_h   : own_q_r;
    dat_we = cmd.append | cmd.remove | cmd.wr_dat_pos;
    dat_wa = cmd.append ? cnt_idx : pos_q_r;
    if (cmd.remove) begin
      dat_wd = dat_q_r;
    end else begin
      dat_wd = pay_r;
    end
    own_re = cmd.rd_last | cmd.rd_dpos;
    own_ra = cmd.rd_last ? last : pidx;
    dat_re = cmd.rd_last | cmd.rd_dpos | cmd.rd_dat_pos;
    if (cmd.rd_last) begin
      dat_ra = last;
    end else if (cmd.rd_dpos) begin
      dat_ra = pidx;
    end else begin
      dat_ra = pos_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (cmd.rd_pos) pos_q_r <= pos_mem[hidx];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_wa] <= own_wd;
    if (own_re) own_q_r <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (dat_we) dat_mem[dat_wa] <= dat_wd;
    if (dat_re) dat_q_r <= dat_mem[dat_ra];
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_status_r <= cmd.out_status;
      o_live_r   <= LIVE_W'(count_r);
      case (cmd.out_sel)
        RS_GET: begin
          o_handle_r  <= HOUT_W'(hidx);
          o_index_r   <= IDX_W'(pos_q_r);
          o_payload_r <= PAYLOAD_W'(dat_q_r);
        end
        RS_SET, RS_REM: begin
          o_handle_r  <= HOUT_W'(hidx);
          o_index_r   <= IDX_W'(pos_q_r);
          o_payload_r <= '0;
        end
        RS_APP: begin
          o_handle_r  <= HOUT_W'(app_h_r);
          o_index_r   <= IDX_W'(app_pos_r);
          o_payload_r <= '0;
        end
        RS_READ: begin
          o_handle_r  <= HOUT_W'(own_q_r);
          o_index_r   <= posn_r;
          o_payload_r <= PAYLOAD_W'(dat_q_r);
        end
        default: begin
          o_handle_r  <= '0;
          o_index_r   <= '0;
          o_payload_r <= '0;
        end
      endcase
    end
  end

  assign out_status  = o_status_r;
  assign out_handle  = o_handle_r;
  assign out_index   = o_index_r;
  assign out_payload = o_payload_r;
  assign out_live    = o_live_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("entry count beyond table size");

  a_append_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (!valid_r[app_h] && !stat.full))
    else $error("append onto a live handle or into a full table");

  a_remove_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> (valid_r[hidx] && !stat.empty))
    else $error("remove of a dead handle");

endmodule

// ===== rtl/sss_ctrl.sv =====
// sss_ctrl: operation sequencer of the sparse set slot table and result handshake
// depends on sss_pkg; commands sss_datapath through dp_cmd_t
module sss_ctrl import sss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_RD1  = 5'b00100,
    S_SRCH = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  res_sel_t sel_r, sel_nxt;
  st_t      st_r, st_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        st_nxt    = ST_OK;
        sel_nxt   = RS_ERR;
        state_nxt = S_FIN;
        case (stat.func)
          FN_GET: begin
            if (stat.h_oor) begin
              st_nxt = ST_OUT_OF_RANGE;
            end else if (!stat.hit) begin
              st_nxt = ST_NOT_FOUND;
            end else begin
              cmd.rd_pos = 1'b1;
              sel_nxt    = RS_GET;
              state_nxt  = S_RD1;
            end
          end
          FN_SET: begin
            if (stat.h_oor) begin
              st_nxt = ST_OUT_OF_RANGE;
            end else if (stat.hit) begin
              cmd.rd_pos = 1'b1;
              sel_nxt    = RS_SET;
              state_nxt  = S_RD1;
            end else if (stat.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.append = 1'b1;
              sel_nxt    = RS_APP;
            end
          end
          FN_ADD: begin
            if (stat.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.grp_ld = 1'b1;
              sel_nxt    = RS_APP;
              state_nxt  = S_SRCH;
            end
          end
          FN_REMOVE: begin
            if (stat.h_oor) begin
              st_nxt = ST_OUT_OF_RANGE;
            end else if (!stat.hit || stat.empty) begin
              st_nxt = ST_NOT_FOUND;
            end else begin
              cmd.rd_pos  = 1'b1;
              cmd.rd_last = 1'b1;
              sel_nxt     = RS_REM;
              state_nxt   = S_RD1;
            end
          end
          FN_READ: begin
            if (stat.p_oor) begin
              st_nxt = ST_OUT_OF_RANGE;
            end else if (stat.p_dead) begin
              st_nxt = ST_NOT_FOUND;
            end else begin
              cmd.rd_dpos = 1'b1;
              sel_nxt     = RS_READ;
            end
          end
          default: begin
            st_nxt = ST_OUT_OF_RANGE;
          end
        endcase
      end
      S_RD1: begin
        state_nxt = S_FIN;
        case (stat.func)
          FN_GET:    cmd.rd_dat_pos = 1'b1;
          FN_SET:    cmd.wr_dat_pos = 1'b1;
          FN_REMOVE: cmd.remove     = 1'b1;
          default:   cmd.rd_dat_pos = 1'b0;
        endcase
      end
      S_SRCH: begin
        cmd.append   = 1'b1;
        cmd.app_srch = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld     = 1'b1;
          cmd.out_sel    = sel_r;
          cmd.out_status = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    st_r  <= st_nxt;
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DEC)
    else $error("accepted word not decoded next cycle");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN && out_valid_r))
    else $error("result overwritten while previous word still waiting");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> (out_valid_r && state_r == S_IDLE))
    else $error("loaded result not presented");

endmodule

// ===== rtl/sparse_set_slot_table.sv =====
// sparse_set_slot_table: top level, sparse set of stable handles over a packed dense array
// depends on sss_pkg, sss_in_if, sss_out_if, sss_ctrl and sss_datapath
//
//   channel   dir  handshake      word
//   in_port   in   valid/ready    func, handle, position, payload
//   out_port  out  valid/ready    status, handle_out, dense_index, payload_out, live_count
//
// get, set of a live handle and remove pass through the decode, read and finish states
// set of a new handle, read_dense and any failing status pass through decode and finish only
// the read state is for the registered read of the position memory feeding the dense memories,
// and add takes a search state in its place, for the group then bit free-handle search
// reset clears the valid bits and entry count at once; no clearing pass
// one word in flight; a new word is taken while the previous result waits in out_port
module sparse_set_slot_table import sss_pkg::*; #(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst_n,
  sss_in_if.sink     in_port,
  sss_out_if.source  out_port
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sss_datapath #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_port.func),
    .in_handle   (in_port.handle),
    .in_position (in_port.position),
    .in_payload  (in_port.payload),
    .out_status  (out_port.status),
    .out_handle  (out_port.handle_out),
    .out_index   (out_port.dense_index),
    .out_payload (out_port.payload_out),
    .out_live    (out_port.live_count)
  );

endmodule
